[sv/assert_macros.svh]
// Assertion macros for the RTL of the rotation matrix unit.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked on the clock edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/earm_pkg.sv]
// Package of the rotation matrix unit: widths, rotation order codes, CORDIC tables.
// No dependencies.
package earm_pkg;

  localparam int FRAC_BITS_DEF     = 14;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_W           = 16;
  localparam int ELEM_W            = 16;
  localparam int OUT_FRAC          = 14;
  localparam int DATA_FRAC         = 30;
  localparam int CORDIC_W          = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_INIT_X = 34'sd652032874;

  typedef enum logic [2:0] {
    ORD_XYZ = 3'd0,
    ORD_XZY = 3'd1,
    ORD_YXZ = 3'd2,
    ORD_YZX = 3'd3,
    ORD_ZXY = 3'd4,
    ORD_ZYX = 3'd5
  } rot_order_t;

  function automatic logic signed [CORDIC_W-1:0] atan_entry(input int idx);
    logic signed [CORDIC_W-1:0] v;
    case (idx)
      0: v = 34'sd536870912;   1: v = 34'sd316933406;   2: v = 34'sd167458907;
      3: v = 34'sd85004756;    4: v = 34'sd42667331;    5: v = 34'sd21354465;
      6: v = 34'sd10679838;    7: v = 34'sd5340245;     8: v = 34'sd2670163;
      9: v = 34'sd1335087;     10: v = 34'sd667544;     11: v = 34'sd333772;
      12: v = 34'sd166886;     13: v = 34'sd83443;      14: v = 34'sd41722;
      15: v = 34'sd20861;      16: v = 34'sd10430;      17: v = 34'sd5215;
      18: v = 34'sd2608;       19: v = 34'sd1304;       20: v = 34'sd652;
      21: v = 34'sd326;        22: v = 34'sd163;        23: v = 34'sd81;
      24: v = 34'sd41;         25: v = 34'sd20;         26: v = 34'sd10;
      27: v = 34'sd5;          28: v = 34'sd3;          29: v = 34'sd1;
      30: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[sv/earm_cordic.sv]
// Pipelined CORDIC sine and cosine of one binary angle, one stage per register.
// Depends on earm_pkg.
module earm_cordic import earm_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [ANGLE_W-1:0]  angle,
  output logic signed [FRAC_BITS+1:0] sin_q,
  output logic signed [FRAC_BITS+1:0] cos_q
);

  localparam int SH = DATA_FRAC - FRAC_BITS;
  localparam logic signed [CORDIC_W-1:0] ONE_Q = CORDIC_W'(1) <<< FRAC_BITS;

  logic signed [CORDIC_W-1:0] x_r [CORDIC_STAGES+1];
  logic signed [CORDIC_W-1:0] y_r [CORDIC_STAGES+1];
  logic signed [CORDIC_W-1:0] z_r [CORDIC_STAGES+1];
  logic                       flip_r [CORDIC_STAGES+1];
  logic signed [FRAC_BITS+1:0] sin_r, cos_r;

  logic [31:0] u_full, u_rot;
  logic        flip_in;

  assign u_full  = {angle, 16'h0000};
  assign flip_in = (u_full[31:30] == 2'b01) || (u_full[31:30] == 2'b10);
  assign u_rot   = flip_in ? (u_full + 32'h8000_0000) : u_full;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= CORDIC_INIT_X;
      y_r[0]    <= '0;
      z_r[0]    <= CORDIC_W'($signed(u_rot));
      flip_r[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][CORDIC_W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_entry(i);
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  function automatic logic signed [FRAC_BITS+1:0] fin(input logic signed [CORDIC_W-1:0] v,
                                                      input logic neg);
    logic signed [CORDIC_W-1:0] t, r;
    t = neg ? -v : v;
    r = (t + (CORDIC_W'(1) <<< (SH-1))) >>> SH;
    if (r > ONE_Q) r = ONE_Q;
    if (r < -ONE_Q) r = -ONE_Q;
    return r[FRAC_BITS+1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= fin(x_r[CORDIC_STAGES], flip_r[CORDIC_STAGES]);
      sin_r <= fin(y_r[CORDIC_STAGES], flip_r[CORDIC_STAGES]);
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

[sv/euler_angles_to_rotation_matrix_unit.sv]
// Top level of the Euler angle to rotation matrix unit.
// Depends on earm_pkg, earm_cordic and assert_macros.svh.
//
//  channel  direction  payload
//  in_      slave      tdata: angle_x, angle_y, angle_z (16 bits signed each)
//  out_     master     tdata: nine Q1.14 elements, column-major (16 bits each)
//  cfg_     write      rotation_order (3 bits)
//
// One item enters per cycle while the pipeline advances; the stages are one input
// register, the CORDIC entry register, CORDIC_STAGES stages, a rounding stage,
// then two matrix products of two stages each (multiply, then sum and round).
// The pipeline advances as a whole whenever the output register is empty or is
// being taken, so a stall freezes every stage and nothing is lost or repeated.
// rst_n is synchronous and clears the valid bits and the rotation order.
module euler_angles_to_rotation_matrix_unit import earm_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // angle_x, angle_y, angle_z from bit 0
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // c0r0,c0r1,c0r2,c1r0,..,c2r2 from bit 0
  input  logic         cfg_we,
  input  logic [2:0]   cfg_wdata   // rotation_order
);

  `include "assert_macros.svh"

  localparam int EW    = FRAC_BITS + 2;          // element width, holds +-1
  localparam int PW    = 2 * EW;                 // product width
  localparam int SW    = PW + 2;                 // three-term sum width
  localparam int DEPTH = CORDIC_STAGES + 7;
  localparam logic signed [SW-1:0] ONE_S = SW'(1) <<< FRAC_BITS;

  typedef logic signed [EW-1:0] elem_t;
  typedef elem_t mat_t [3][3];

  logic en;
  logic [DEPTH-1:0] vld_r;
  logic [2:0] order_r;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORD_XYZ;
      vld_r   <= '0;
    end else begin
      if (cfg_we) order_r <= cfg_wdata;
      if (en) vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end
  assign out_tvalid = vld_r[DEPTH-1];

  // Input register.
  logic signed [ANGLE_W-1:0] ax_r, ay_r, az_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= in_tdata[15:0];
      ay_r <= in_tdata[31:16];
      az_r <= in_tdata[47:32];
    end
  end

  elem_t sx, cx, sy, cy, sz, cz;
  earm_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cx
    (.clk(clk), .en(en), .angle(ax_r), .sin_q(sx), .cos_q(cx));
  earm_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cy
    (.clk(clk), .en(en), .angle(ay_r), .sin_q(sy), .cos_q(cy));
  earm_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cz
    (.clk(clk), .en(en), .angle(az_r), .sin_q(sz), .cos_q(cz));

  // Elementary matrices and operand selection, [row][col].
  mat_t mx, my, mz, p_m, q_m, r_m;
  elem_t one_e;
  assign one_e = EW'(1) <<< FRAC_BITS;

  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        mx[i][j] = '0; my[i][j] = '0; mz[i][j] = '0;
      end
    mx[0][0] = one_e; mx[1][1] = cx; mx[1][2] = -sx; mx[2][1] = sx; mx[2][2] = cx;
    my[1][1] = one_e; my[0][0] = cy; my[0][2] = sy; my[2][0] = -sy; my[2][2] = cy;
    mz[2][2] = one_e; mz[0][0] = cz; mz[0][1] = -sz; mz[1][0] = sz; mz[1][1] = cz;
    unique case (order_r)
      ORD_XZY: begin p_m = mx; q_m = mz; r_m = my; end
      ORD_YXZ: begin p_m = my; q_m = mx; r_m = mz; end
      ORD_YZX: begin p_m = my; q_m = mz; r_m = mx; end
      ORD_ZXY: begin p_m = mz; q_m = mx; r_m = my; end
      ORD_ZYX: begin p_m = mz; q_m = my; r_m = mx; end
      default: begin p_m = mx; q_m = my; r_m = mz; end
    endcase
  end

  function automatic elem_t rnd_clamp(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] r;
    r = (s + (SW'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
    if (r > ONE_S) r = ONE_S;
    if (r < -ONE_S) r = -ONE_S;
    return r[EW-1:0];
  endfunction

  // First product t = q * p: multiply stage, then sum stage. r travels along.
  logic signed [PW-1:0] pa_r [3][3][3];
  mat_t r1_r, r2_r, t_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++)
            pa_r[i][j][k] <= PW'(q_m[i][k]) * PW'(p_m[k][j]);
      r1_r <= r_m;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          t_r[i][j] <= rnd_clamp(SW'(pa_r[i][j][0]) + SW'(pa_r[i][j][1])
                                 + SW'(pa_r[i][j][2]));
      r2_r <= r1_r;
    end
  end

  // Second product m = r * t.
  logic signed [PW-1:0] pb_r [3][3][3];
  mat_t m_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++)
            pb_r[i][j][k] <= PW'(r2_r[i][k]) * PW'(t_r[k][j]);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          m_r[i][j] <= rnd_clamp(SW'(pb_r[i][j][0]) + SW'(pb_r[i][j][1])
                                 + SW'(pb_r[i][j][2]));
    end
  end

  // Output scaling to Q1.14.
  function automatic logic [ELEM_W-1:0] to_out(input elem_t v);
    logic signed [EW+OUT_FRAC:0] w;
    if (FRAC_BITS >= OUT_FRAC) begin
      if (FRAC_BITS > OUT_FRAC)
        w = ((EW+OUT_FRAC+1)'(v) + ((EW+OUT_FRAC+1)'(1) <<< (FRAC_BITS-OUT_FRAC-1)))
            >>> (FRAC_BITS - OUT_FRAC);
      else
        w = (EW+OUT_FRAC+1)'(v);
    end else begin
      w = (EW+OUT_FRAC+1)'(v) <<< (OUT_FRAC - FRAC_BITS);
    end
    if (w > 16384) w = 16384;
    if (w < -16384) w = -16384;
    return w[ELEM_W-1:0];
  endfunction

  always_comb begin
    for (int j = 0; j < 3; j++)
      for (int i = 0; i < 3; i++)
        out_tdata[(j*3+i)*ELEM_W +: ELEM_W] = to_out(m_r[i][j]);
  end

  `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "output dropped while stalled")
  `ASSERT_NEXT(a_shift, clk, rst_n, en && in_tvalid, vld_r[0], "accepted transfer not tracked")
  `ASSERT_IMPL(a_ready, clk, rst_n, !out_tvalid, in_tready, "input blocked with empty output")

endmodule
